[rtl/i2a_pkg.sv]
package i2a_pkg;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_OCT  = 3'd2;
    localparam logic [2:0] MODE_HEXL = 3'd3;
    localparam logic [2:0] MODE_HEXU = 3'd4;
    localparam logic [2:0] MODE_PTR  = 3'd5;

    localparam logic [1:0] SZ_INT  = 2'd0;
    localparam logic [1:0] SZ_8    = 2'd1;
    localparam logic [1:0] SZ_16   = 2'd2;
    localparam logic [1:0] SZ_FULL = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;

    function automatic logic [7:0] ascii_digit(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10) begin
            return CH_ZERO + {4'd0, d};
        end
        base = upper ? CH_UP_A : CH_LOW_A;
        return base + {4'd0, d} - 8'd10;
    endfunction

endpackage

[rtl/integer_to_ascii_formatter.sv]
// Phases: a load, then a bit-serial conversion phase for decimal modes
// (none for octal, hex and pointer), a skip of up to NCELL-1 leading zero digits,
// then any prefix characters and one output word per cycle while out_stall is low.
// A new word is taken only when the previous number has left the digit chain,
// so the block does not take a new number before it is through with the last one.
// rst_n clears the controller and the output valid asynchronously.
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] value,
    input  logic [2:0]  mode,
    input  logic [1:0]  size_class,
    input  logic        plus_flag,
    input  logic        space_flag,
    input  logic        alt_flag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        last
);
    import i2a_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int NCELL = (W + 2) / 3;
    localparam int DEF_W = (W < 32) ? W : 32;
    localparam int CW    = $clog2(W);
    localparam int RW    = $clog2(NCELL + 1);
    localparam int PADW  = 4 * NCELL;

    localparam logic [W-1:0] MASK_DEF  = {W{1'b1}} >> (W - DEF_W);
    localparam logic [W-1:0] MASK_8    = {W{1'b1}} >> (W - 8);
    localparam logic [W-1:0] MASK_16   = {W{1'b1}} >> (W - 16);
    localparam logic [W-1:0] MASK_FULL = {W{1'b1}};
    localparam logic [CW-1:0] CONV_LAST = CW'(W - 1);
    localparam logic [RW-1:0] REM_FULL  = RW'(NCELL);
    localparam logic [RW-1:0] REM_ONE   = RW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_PRE,
        S_DIG
    } state_t;

    state_t        state_reg, state_next;
    logic [W-1:0]  sh_reg, sh_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [1:0]    pre_cnt_reg, pre_cnt_next;
    logic [7:0]    pre0_reg, pre0_next;
    logic [7:0]    pre1_reg, pre1_next;
    logic          upper_reg, upper_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic          last_reg, last_next;

    logic [W-1:0]    v;
    logic [W-1:0]    mask;
    logic [W-1:0]    x;
    logic [W-1:0]    mag;
    logic [PADW-1:0] mag_pad;
    logic            neg;
    logic            accept;
    logic            out_free;
    logic            skip_zero;
    logic            digits_ok;
    logic [3:0]      load_dig [NCELL];
    logic [3:0]      dig      [NCELL];
    logic            carry    [NCELL];
    logic [3:0]      top_dig;
    cell_ctrl_t      ctrl;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign top_dig   = dig[NCELL-1];
    assign skip_zero = (top_dig == 4'd0) && (rem_reg > REM_ONE);

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    always_comb
    begin
        v = value[W-1:0];
        case (size_class)
            SZ_8:    mask = MASK_8;
            SZ_16:   mask = MASK_16;
            SZ_FULL: mask = MASK_FULL;
            default: mask = MASK_DEF;
        endcase
        x   = v & mask;
        neg = (mode == MODE_SDEC)
              && (((size_class == SZ_INT) && x[DEF_W-1])
                  || ((size_class == SZ_FULL) && x[W-1]));
        if (mode == MODE_PTR)
        begin
            mag = v;
        end
        else if (neg)
        begin
            mag = (~x + {{(W-1){1'b0}}, 1'b1}) & mask;
        end
        else
        begin
            mag = x;
        end
        mag_pad = PADW'(mag);
        for (int i = 0; i < NCELL; i++)
        begin
            if (mode == MODE_OCT)
            begin
                load_dig[i] = {1'b0, mag_pad[3*i +: 3]};
            end
            else if ((mode == MODE_HEXL) || (mode == MODE_HEXU) || (mode == MODE_PTR))
            begin
                load_dig[i] = mag_pad[4*i +: 4];
            end
            else
            begin
                load_dig[i] = 4'd0;
            end
        end
    end

    always_comb
    begin
        ctrl.load   = accept;
        ctrl.dabble = (state_reg == S_CONV);
        ctrl.shift  = ((state_reg == S_SKIP) && skip_zero)
                      || ((state_reg == S_DIG) && out_free);
    end

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            logic       b_in;
            logic [3:0] d_in;
            if (g == 0)
            begin : g_first
                assign b_in = sh_reg[W-1];
                assign d_in = 4'd0;
            end
            else
            begin : g_rest
                assign b_in = carry[g-1];
                assign d_in = dig[g-1];
            end
            i2a_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .load_digit (load_dig[g]),
                .bit_in     (b_in),
                .digit_in   (d_in),
                .digit      (dig[g]),
                .bit_out    (carry[g])
            );
        end
    endgenerate

    always_comb
    begin
        digits_ok = 1'b1;
        for (int i = 0; i < NCELL; i++)
        begin
            if (dig[i] > 4'd9)
            begin
                digits_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sh_next        = sh_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        pre_cnt_next   = pre_cnt_reg;
        pre0_next      = pre0_reg;
        pre1_next      = pre1_reg;
        upper_next     = upper_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sh_next      = mag;
                    cnt_next     = '0;
                    rem_next     = REM_FULL;
                    upper_next   = (mode == MODE_HEXU) || (mode == MODE_PTR);
                    pre_cnt_next = 2'd0;
                    pre0_next    = CH_ZERO;
                    pre1_next    = CH_LOW_X;
                    state_next   = S_SKIP;
                    case (mode)
                        MODE_SDEC:
                        begin
                            state_next = S_CONV;
                            if (neg)
                            begin
                                pre0_next    = CH_MINUS;
                                pre_cnt_next = 2'd1;
                            end
                            else if (plus_flag)
                            begin
                                pre0_next    = CH_PLUS;
                                pre_cnt_next = 2'd1;
                            end
                            else if (space_flag)
                            begin
                                pre0_next    = CH_SPACE;
                                pre_cnt_next = 2'd1;
                            end
                        end
                        MODE_UDEC: state_next = S_CONV;
                        MODE_OCT:  pre_cnt_next = alt_flag ? 2'd1 : 2'd0;
                        MODE_HEXL: pre_cnt_next = alt_flag ? 2'd2 : 2'd0;
                        MODE_HEXU:
                        begin
                            pre1_next    = CH_UP_X;
                            pre_cnt_next = alt_flag ? 2'd2 : 2'd0;
                        end
                        MODE_PTR:  pre_cnt_next = 2'd2;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CONV:
            begin
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CONV_LAST)
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (skip_zero)
                begin
                    rem_next = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = (pre_cnt_reg != 2'd0) ? S_PRE : S_DIG;
                end
            end
            S_PRE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = pre0_reg;
                    last_next      = 1'b0;
                    pre0_next      = pre1_reg;
                    pre_cnt_next   = pre_cnt_reg - 1'b1;
                    if (pre_cnt_reg == 2'd1)
                    begin
                        state_next = S_DIG;
                    end
                end
            end
            S_DIG:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ascii_digit(top_dig, upper_reg);
                    last_next      = (rem_reg == REM_ONE);
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == REM_ONE)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sh_reg        <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            pre_cnt_reg   <= 2'd0;
            pre0_reg      <= 8'd0;
            pre1_reg      <= 8'd0;
            upper_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= 8'd0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sh_reg        <= sh_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            pre_cnt_reg   <= pre_cnt_next;
            pre0_reg      <= pre0_next;
            pre1_reg      <= pre1_next;
            upper_reg     <= upper_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            last_reg      <= last_next;
        end
    end

    a_dig_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIG) |-> (rem_reg != '0))
        else $error("digit phase entered with no digits left");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIG) && out_free && (rem_reg == REM_ONE)
        |=> (state_reg == S_IDLE) && out_valid && last)
        else $error("final digit did not close the number");

    a_pre_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRE) |-> (pre_cnt_reg != 2'd0))
        else $error("prefix phase with empty prefix");

    a_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV) |-> digits_ok)
        else $error("decimal digit chain left BCD range");

endmodule

[rtl/i2a_cell.sv]
module i2a_cell (
    input  logic                   clk,
    input  i2a_pkg::cell_ctrl_t    ctrl,
    input  logic [3:0]             load_digit,
    input  logic                   bit_in,
    input  logic [3:0]             digit_in,
    output logic [3:0]             digit,
    output logic                   bit_out
);
    import i2a_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Add three before the shift keeps the digit in BCD range.
    assign adj     = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out = adj[3];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.load)
        begin
            digit_next = load_digit;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule
